// ===== rtl/gradient_noise_2d_defines.svh =====
// assertion macros for the gradient noise block
`ifndef GRADIENT_NOISE_2D_DEFINES_SVH
`define GRADIENT_NOISE_2D_DEFINES_SVH

`ifndef ASSERT_OFF
`define GN2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GN2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GN2D_ASSERT_IMP(lbl, ante, cons, msg)
`define GN2D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/gn2d_pkg.sv =====
// shared constants, types and helpers of the gradient noise block
package gn2d_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;
  localparam int GRAD_BITS  = 16;

  localparam int COORD_W = 32;
  localparam int GRAD_W  = 16;
  localparam int INDEX_W = 8;
  localparam int OUT_W   = 19;
  localparam int CORNERS = 4;

  localparam int ADDR_W  = $clog2(TABLE_SIZE);
  localparam int INT_W   = COORD_W - FRAC_BITS;
  localparam int HASH_W  = INT_W + 12;
  localparam int ENTRY_W = 2 * GRAD_W;
  localparam int OFF_W   = FRAC_BITS + 1;
  localparam int PROD_W  = OFF_W + GRAD_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DOT_W   = SUM_W - (GRAD_BITS - 1);
  localparam int DIFF_W  = DOT_W + 1;
  localparam int LPROD_W = DIFF_W + OFF_W;
  localparam int LSUM_W  = LPROD_W - FRAC_BITS;

  localparam int HASH_MUL_X = 713;
  localparam int HASH_ADD   = 413;
  localparam int HASH_MUL_Y = 637;
  localparam int CORNER_ADD [CORNERS] = '{0, HASH_MUL_X, HASH_MUL_Y, HASH_MUL_X + HASH_MUL_Y};

  localparam int NOISE_BOUND = 1 << (FRAC_BITS + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic        [ADDR_W-1:0]  addr_t;
  typedef logic        [FRAC_BITS-1:0] frac_t;
  typedef logic        [ENTRY_W-1:0] entry_t;
  typedef logic signed [HASH_W-1:0]  hash_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [OUT_W-1:0]   noise_t;

  typedef struct packed {
    logic                           we;
    logic [CORNERS-1:0][ADDR_W-1:0] addr;
    entry_t                         wdata;
  } ram_req_t;

  typedef struct packed {
    logic  valid;
    frac_t fx;
    frac_t fy;
  } tag_t;

  // |h| mod table size, table size a power of two
  function automatic addr_t hash_to_addr(input hash_t h);
    addr_t low;
    low = h[ADDR_W-1:0];
    return h[HASH_W-1] ? addr_t'(~low + 1'b1) : low;
  endfunction

endpackage

// ===== rtl/gradient_noise_2d.sv =====
// top level of the two-dimensional gradient noise block
//
// Takes one transaction per clock: busy never rises, so start may be held high
// every cycle. A load transaction (in_operation low) writes one gradient into
// the 256-entry table; it gives no result. An evaluate transaction gives its
// noise value on out_noise_value with out_valid high for exactly one cycle,
// in the order the points came in, once it has passed the nine stages: the
// input register, the corner hash, the gradient table read, the gradient
// multiply, the dot sum, two for the x blend and two for the y blend, the
// second of which is the result register.
// The table is held as four copies so all four corners are read in one cycle;
// a load written right before an evaluate is seen by it. Table entries are
// undefined after reset until loaded, and an evaluate that hits an unloaded
// entry returns an undefined value. The result output cannot be stalled.
`include "gradient_noise_2d_defines.svh"

module gradient_noise_2d (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic [gn2d_pkg::INDEX_W-1:0] in_table_index,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  in_grad_x,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  in_grad_y,
  input  logic signed [gn2d_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [gn2d_pkg::COORD_W-1:0] in_y_coord,
  output logic                         out_valid,
  output logic signed [gn2d_pkg::OUT_W-1:0]   out_noise_value
);
  import gn2d_pkg::*;

  logic                 in_valid_r, in_op_r;
  logic [INDEX_W-1:0]   in_index_r;
  logic [GRAD_W-1:0]    in_gx_r, in_gy_r;
  logic [COORD_W-1:0]   in_x_r, in_y_r;
  logic                 eval_acc;
  logic                 noise_in_range;

  ram_req_t                          ram_req;
  tag_t                              tag3, tag5;
  logic [CORNERS-1:0][ENTRY_W-1:0]   grad_rd;
  logic [CORNERS-1:0][DOT_W-1:0]     dots;
  noise_t                            noise;

  assign busy     = 1'b0;
  assign eval_acc = start && !busy && (in_operation == OP_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    in_op_r    <= in_operation;
    in_index_r <= in_table_index;
    in_gx_r    <= in_grad_x;
    in_gy_r    <= in_grad_y;
    in_x_r     <= in_x_coord;
    in_y_r     <= in_y_coord;
  end

  gn2d_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid_r),
    .op_in     (in_op_r),
    .index_in  (in_index_r),
    .grad_x_in (in_gx_r),
    .grad_y_in (in_gy_r),
    .x_in      (in_x_r),
    .y_in      (in_y_r),
    .ram_req   (ram_req),
    .tag_out   (tag3)
  );

  for (genvar i = 0; i < CORNERS; i++) begin : g_table
    gn2d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
    ) u_ram (
      .clk   (clk),
      .we    (ram_req.we),
      .addr  (ram_req.addr[i]),
      .wdata (ram_req.wdata),
      .rdata (grad_rd[i])
    );
  end

  gn2d_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag3),
    .grad_in (grad_rd),
    .tag_out (tag5),
    .dot_out (dots)
  );

  gn2d_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag5),
    .dot_in    (dots),
    .valid_out (out_valid),
    .noise_out (noise)
  );

  assign out_noise_value = noise;

  assign noise_in_range = (noise <= OUT_W'(NOISE_BOUND)) && (noise >= -OUT_W'(NOISE_BOUND));

  `GN2D_ASSERT_IMP(a_result_from_eval, out_valid, $past(eval_acc, 9), "result without evaluate")
  `GN2D_ASSERT_NEXT(a_load_no_eval, ram_req.we, !tag3.valid, "load transaction reached dot stage")
  `GN2D_ASSERT_IMP(a_noise_bound, out_valid, noise_in_range, "noise value out of range")

endmodule

// ===== rtl/gn2d_ram.sv =====
// generic single port ram with registered read
module gn2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gn2d_hash.sv =====
// corner hashing and gradient table port control
module gn2d_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_in,
  input  logic                       op_in,
  input  logic [gn2d_pkg::INDEX_W-1:0] index_in,
  input  logic [gn2d_pkg::GRAD_W-1:0]  grad_x_in,
  input  logic [gn2d_pkg::GRAD_W-1:0]  grad_y_in,
  input  logic [gn2d_pkg::COORD_W-1:0] x_in,
  input  logic [gn2d_pkg::COORD_W-1:0] y_in,
  output gn2d_pkg::ram_req_t         ram_req,
  output gn2d_pkg::tag_t             tag_out
);
  import gn2d_pkg::*;

  logic signed [INT_W-1:0] cx, cy;
  hash_t                   h00_nxt;

  logic   valid2_r, op2_r;
  addr_t  index2_r;
  entry_t wdata2_r;
  hash_t  h00_r;
  frac_t  fx2_r, fy2_r;

  logic  valid3_r;
  frac_t fx3_r, fy3_r;

  assign cx = $signed(x_in[COORD_W-1:FRAC_BITS]);
  assign cy = $signed(y_in[COORD_W-1:FRAC_BITS]);
  assign h00_nxt = hash_t'(cx) * hash_t'(HASH_MUL_X) + hash_t'(cy) * hash_t'(HASH_MUL_Y)
                 + hash_t'(HASH_ADD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid2_r <= valid_in;
      valid3_r <= valid2_r && (op2_r == OP_EVAL);
    end
    op2_r    <= op_in;
    index2_r <= index_in[ADDR_W-1:0];
    wdata2_r <= {grad_x_in, grad_y_in};
    h00_r    <= h00_nxt;
    fx2_r    <= x_in[FRAC_BITS-1:0];
    fy2_r    <= y_in[FRAC_BITS-1:0];
    fx3_r    <= fx2_r;
    fy3_r    <= fy2_r;
  end

  // loads write every copy, evaluates read one corner per copy
  always_comb begin
    ram_req.we    = valid2_r && (op2_r == OP_LOAD);
    ram_req.wdata = wdata2_r;
    for (int i = 0; i < CORNERS; i++) begin
      ram_req.addr[i] = (op2_r == OP_LOAD) ? index2_r
                      : hash_to_addr(h00_r + hash_t'(CORNER_ADD[i]));
    end
  end

  assign tag_out.valid = valid3_r;
  assign tag_out.fx    = fx3_r;
  assign tag_out.fy    = fy3_r;

endmodule

// ===== rtl/gn2d_dot.sv =====
// corner dot products of gradient and offset
module gn2d_dot (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  gn2d_pkg::tag_t                                 tag_in,
  input  logic [gn2d_pkg::CORNERS-1:0][gn2d_pkg::ENTRY_W-1:0] grad_in,
  output gn2d_pkg::tag_t                                 tag_out,
  output logic [gn2d_pkg::CORNERS-1:0][gn2d_pkg::DOT_W-1:0]   dot_out
);
  import gn2d_pkg::*;

  logic signed [OFF_W-1:0] dx_lo, dx_hi, dy_lo, dy_hi;
  logic signed [PROD_W-1:0] px_nxt [CORNERS];
  logic signed [PROD_W-1:0] py_nxt [CORNERS];
  logic signed [PROD_W-1:0] px_r [CORNERS];
  logic signed [PROD_W-1:0] py_r [CORNERS];
  logic signed [SUM_W-1:0]  sum [CORNERS];
  logic [CORNERS-1:0][DOT_W-1:0] dot_r;

  logic  valid4_r, valid5_r;
  frac_t fx4_r, fy4_r, fx5_r, fy5_r;

  // upper corner offset is fraction minus one
  assign dx_lo = $signed({1'b0, tag_in.fx});
  assign dx_hi = $signed({1'b1, tag_in.fx});
  assign dy_lo = $signed({1'b0, tag_in.fy});
  assign dy_hi = $signed({1'b1, tag_in.fy});

  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      px_nxt[i] = (i[0] ? dx_hi : dx_lo) * $signed(grad_in[i][ENTRY_W-1:GRAD_W]);
      py_nxt[i] = (i[1] ? dy_hi : dy_lo) * $signed(grad_in[i][GRAD_W-1:0]);
      sum[i]    = SUM_W'(px_r[i]) + SUM_W'(py_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid4_r <= 1'b0;
      valid5_r <= 1'b0;
    end else begin
      valid4_r <= tag_in.valid;
      valid5_r <= valid4_r;
    end
    fx4_r <= tag_in.fx;
    fy4_r <= tag_in.fy;
    fx5_r <= fx4_r;
    fy5_r <= fy4_r;
    for (int i = 0; i < CORNERS; i++) begin
      px_r[i]  <= px_nxt[i];
      py_r[i]  <= py_nxt[i];
      dot_r[i] <= sum[i][SUM_W-1:GRAD_BITS-1];
    end
  end

  assign tag_out.valid = valid5_r;
  assign tag_out.fx    = fx5_r;
  assign tag_out.fy    = fy5_r;
  assign dot_out       = dot_r;

endmodule

// ===== rtl/gn2d_lerp.sv =====
// linear blend along x then y, saturation and result register
module gn2d_lerp (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  gn2d_pkg::tag_t                               tag_in,
  input  logic [gn2d_pkg::CORNERS-1:0][gn2d_pkg::DOT_W-1:0] dot_in,
  output logic                                         valid_out,
  output gn2d_pkg::noise_t                             noise_out
);
  import gn2d_pkg::*;

  localparam logic signed [LSUM_W-1:0] SAT_HI = LSUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [LSUM_W-1:0] SAT_LO = LSUM_W'(-(1 << (OUT_W - 1)));

  logic signed [DIFF_W-1:0]  dlo, dhi, dv;
  logic signed [OFF_W-1:0]   wx, wy;
  logic signed [LPROD_W-1:0] mlo_nxt, mhi_nxt, mv_nxt;
  logic signed [LSUM_W-1:0]  lo_sum, hi_sum, v_sum;

  logic signed [LPROD_W-1:0] mlo_r, mhi_r, mv_r;
  dot_t  alo_r, ahi_r, lo_r, hi_r, lo8_r;
  frac_t fy6_r, fy7_r;
  logic  valid6_r, valid7_r, valid8_r, valid9_r;
  noise_t noise_r, noise_nxt;

  assign wx  = $signed({1'b0, tag_in.fx});
  assign dlo = DIFF_W'($signed(dot_in[1])) - DIFF_W'($signed(dot_in[0]));
  assign dhi = DIFF_W'($signed(dot_in[3])) - DIFF_W'($signed(dot_in[2]));
  assign mlo_nxt = dlo * wx;
  assign mhi_nxt = dhi * wx;

  assign lo_sum = LSUM_W'(alo_r) + $signed(mlo_r[LPROD_W-1:FRAC_BITS]);
  assign hi_sum = LSUM_W'(ahi_r) + $signed(mhi_r[LPROD_W-1:FRAC_BITS]);

  assign wy     = $signed({1'b0, fy7_r});
  assign dv     = DIFF_W'(hi_r) - DIFF_W'(lo_r);
  assign mv_nxt = dv * wy;

  assign v_sum = LSUM_W'(lo8_r) + $signed(mv_r[LPROD_W-1:FRAC_BITS]);

  always_comb begin
    if (v_sum > SAT_HI) begin
      noise_nxt = noise_t'(SAT_HI);
    end else if (v_sum < SAT_LO) begin
      noise_nxt = noise_t'(SAT_LO);
    end else begin
      noise_nxt = noise_t'(v_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid6_r <= 1'b0;
      valid7_r <= 1'b0;
      valid8_r <= 1'b0;
      valid9_r <= 1'b0;
    end else begin
      valid6_r <= tag_in.valid;
      valid7_r <= valid6_r;
      valid8_r <= valid7_r;
      valid9_r <= valid8_r;
    end
    mlo_r   <= mlo_nxt;
    mhi_r   <= mhi_nxt;
    alo_r   <= $signed(dot_in[0]);
    ahi_r   <= $signed(dot_in[2]);
    fy6_r   <= tag_in.fy;
    lo_r    <= dot_t'(lo_sum);
    hi_r    <= dot_t'(hi_sum);
    fy7_r   <= fy6_r;
    mv_r    <= mv_nxt;
    lo8_r   <= lo_r;
    noise_r <= noise_nxt;
  end

  assign valid_out = valid9_r;
  assign noise_out = noise_r;

endmodule
